### design/pewc_pkg.sv
// ----------------------------------------------------------------------------
// pewc_pkg
// Shared types and constants of the parallel EEPROM write cycle block.
// ----------------------------------------------------------------------------
package pewc_pkg;

    localparam int DATA_BYTES  = 2048;
    localparam int ID_BYTES    = 32;
    localparam int TOTAL_BYTES = DATA_BYTES + ID_BYTES;
    localparam int ADDR_W      = $clog2(TOTAL_BYTES);

    localparam logic [7:0]  POLL_FLIP   = 8'h80;
    localparam logic [7:0]  ERASED_BYTE = 8'hFF;
    localparam logic [15:0] CYCLE_RESET = 16'd200;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] address;
        logic [7:0]  wr_data;
        logic        a9_high_voltage;
        logic        oe_high_voltage;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       busy_res;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_POLL,
        RES_RAM
    } res_sel_t;

    typedef enum logic [1:0] {
        ASEL_IN,
        ASEL_HELD,
        ASEL_CLEAR
    } addr_sel_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      ram_we;
        logic      wdata_erased;
        logic      latch_in;
        logic      clear_rst;
        logic      clear_step;
        logic      start_erase;
        logic      start_prog;
        logic      do_tick;
        logic      emit;
        res_sel_t  res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       oe;
        logic       in_progress;
        logic       differ;
        logic       clear_last;
    } dp_status_t;

endpackage

### design/parallel_eeprom_write_cycle.sv
// ----------------------------------------------------------------------------
// parallel_eeprom_write_cycle
// 2Kx8 parallel EEPROM model with ID area, busy timer and data polling.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a word on item and raise start; the word is taken at a clock edge
//   where start is high and busy is low. Each word gives one result word on
//   result, marked by done for exactly one cycle; the receiver cannot stall.
//   Ticks, ignored writes, polled reads and chip erase give done in the cycle
//   after they are accepted; array reads and byte writes first pass through
//   the registered RAM read, then a step to form or compare the byte.
//   Throughput is set by the single RAM port: one word per cycle for ticks
//   and polled accesses while busy is low; an array access holds busy until
//   its result is formed. Reset clears the busy timer and starts a sweep that
//   writes 0xFF into all 2080 bytes, one per cycle; busy stays high until the
//   sweep ends. A chip erase runs the same sweep as its result is given.
//   The cycle length register is written through cfg_we/cfg_wdata at any
//   edge; a new length applies to the next program or erase.
// ----------------------------------------------------------------------------
module parallel_eeprom_write_cycle import pewc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_word_t    item,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        done,
    output out_word_t   result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: decode the accepted word and step through the RAM access.
    pewc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: cell array, busy timer, last programmed byte, result word.
    pewc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

    // A tick always answers in the next cycle.
    a_tick_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_TICK) |=> done)
        else $error("tick without a result word");

    // A read either answers at once (polling) or holds busy for the RAM read.
    a_read_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_READ) |=> (done || busy))
        else $error("read neither answered nor in progress");

    // The array is written only while the sequencer holds off new words.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_we |-> busy)
        else $error("array written while idle");

    // A program or erase reports busy in its own result.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_prog || cmd.start_erase) |=> (done && result.busy_res))
        else $error("program or erase result not busy");

endmodule

### design/pewc_ram.sv
// ----------------------------------------------------------------------------
// pewc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pewc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        q <= mem[addr];
    end

endmodule

### design/pewc_ctrl.sv
// ----------------------------------------------------------------------------
// pewc_ctrl
// Sequencer: clear sweep, access decode and read/compare steps.
// ----------------------------------------------------------------------------
module pewc_ctrl import pewc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel = ASEL_IN;
        cmd.res_sel  = RES_ZERO;
        state_next = state_reg;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.addr_sel     = ASEL_CLEAR;
                cmd.ram_we       = 1'b1;
                cmd.wdata_erased = 1'b1;
                cmd.clear_step   = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    case (status.op)
                        OP_READ:
                        begin
                            if (status.in_progress)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.res_sel = RES_POLL;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (status.in_progress)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else if (status.oe)
                            begin
                                cmd.start_erase = 1'b1;
                                cmd.clear_rst   = 1'b1;
                                cmd.emit        = 1'b1;
                                state_next      = ST_CLEAR;
                            end
                            else
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        OP_TICK:
                        begin
                            cmd.do_tick = 1'b1;
                            cmd.emit    = 1'b1;
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.emit    = 1'b1;
                cmd.res_sel = RES_RAM;
                state_next  = ST_IDLE;
            end
            ST_CHECK:
            begin
                // program only a byte that changes
                cmd.addr_sel = ASEL_HELD;
                cmd.emit     = 1'b1;
                if (status.differ)
                begin
                    cmd.ram_we     = 1'b1;
                    cmd.start_prog = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/pewc_datapath.sv
// ----------------------------------------------------------------------------
// pewc_datapath
// Cell array, address mapping, busy timer and result register.
// ----------------------------------------------------------------------------
module pewc_datapath import pewc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  in_word_t    item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    output logic        done,
    output out_word_t   result
);

    function automatic logic [ADDR_W-1:0] map_addr(logic [10:0] a, logic a9);
        logic [ADDR_W-1:0] m;
        m = ADDR_W'(a % DATA_BYTES);
        if (a9 && (m >= ADDR_W'(DATA_BYTES - ID_BYTES)))
        begin
            m = m + ADDR_W'(ID_BYTES);
        end
        return m;
    endfunction

    logic [15:0]       cycle_ticks_reg;
    logic [15:0]       ticks_left_reg;
    logic [15:0]       ticks_left_next;
    logic              in_progress_reg;
    logic              in_progress_next;
    logic [7:0]        last_prog_reg;
    logic [7:0]        last_prog_next;
    logic [ADDR_W-1:0] clear_cnt_reg;
    in_word_t          held_reg;
    logic [ADDR_W-1:0] held_addr_reg;
    logic              done_reg;
    out_word_t         result_reg;
    out_word_t         result_next;

    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_q;
    logic [15:0]       ticks_dec;
    logic [15:0]       ticks_load;

    always_comb
    begin
        case (cmd.addr_sel)
            ASEL_HELD:  ram_addr = held_addr_reg;
            ASEL_CLEAR: ram_addr = clear_cnt_reg;
            default:    ram_addr = map_addr(item.address, item.a9_high_voltage);
        endcase
    end

    assign ram_wdata = cmd.wdata_erased ? ERASED_BYTE : held_reg.wr_data;

    pewc_ram #(
        .WIDTH (8),
        .DEPTH (TOTAL_BYTES)
    ) u_cells (
        .clk   (clk),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .q     (ram_q)
    );

    assign ticks_dec  = ticks_left_reg - {15'd0, (ticks_left_reg != 16'd0)};
    assign ticks_load = (cycle_ticks_reg == 16'd0) ? 16'd1 : cycle_ticks_reg;

    always_comb
    begin
        in_progress_next = in_progress_reg;
        ticks_left_next  = ticks_left_reg;
        last_prog_next   = last_prog_reg;
        if (cmd.start_erase || cmd.start_prog)
        begin
            in_progress_next = 1'b1;
            ticks_left_next  = ticks_load;
            last_prog_next   = cmd.start_erase ? ERASED_BYTE : held_reg.wr_data;
        end
        else if (cmd.do_tick && in_progress_reg)
        begin
            ticks_left_next  = ticks_dec;
            in_progress_next = (ticks_dec != 16'd0);
        end
    end

    always_comb
    begin
        case (cmd.res_sel)
            RES_POLL: result_next.read_data = last_prog_reg ^ POLL_FLIP;
            RES_RAM:  result_next.read_data = ram_q;
            default:  result_next.read_data = 8'd0;
        endcase
        result_next.busy_res = in_progress_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_ticks_reg <= CYCLE_RESET;
            ticks_left_reg  <= 16'd0;
            in_progress_reg <= 1'b0;
            last_prog_reg   <= 8'd0;
            clear_cnt_reg   <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cycle_ticks_reg <= cfg_wdata;
            end
            ticks_left_reg  <= ticks_left_next;
            in_progress_reg <= in_progress_next;
            last_prog_reg   <= last_prog_next;
            if (cmd.clear_rst)
            begin
                clear_cnt_reg <= '0;
            end
            else if (cmd.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
            end
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            held_reg      <= item;
            held_addr_reg <= map_addr(item.address, item.a9_high_voltage);
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign status.op          = item.op;
    assign status.oe          = item.oe_high_voltage;
    assign status.in_progress = in_progress_reg;
    assign status.differ      = (ram_q != held_reg.wr_data);
    assign status.clear_last  = (clear_cnt_reg == ADDR_W'(TOTAL_BYTES - 1));

    assign done   = done_reg;
    assign result = result_reg;

endmodule
